@@ sv/slg_pkg.sv @@
`timescale 1ns / 1ps

package slg_pkg;

  localparam int unsigned MS_TICKS_DEF = 168000;

  localparam logic [31:0] LIFESPAN_MIN_MS = 32'd1000;
  localparam logic [31:0] LIFESPAN_MAX_MS = 32'd2592000000;
  localparam logic [31:0] SILENT_RESET    = 32'd2520000000;
  localparam logic [31:0] START_RESET     = 32'd0;

  localparam logic [63:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned MIX_SHIFT_A  = 30;
  localparam int unsigned MIX_SHIFT_B  = 27;
  localparam int unsigned MIX_SHIFT_C  = 31;
  localparam int unsigned FINAL_ROTATE = 13;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFESPAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd2;

  localparam logic OP_VALIDATE = 1'b0;
  localparam logic OP_FORCE    = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_TRACK = 10'b00_0000_0010,
    ST_CHECK = 10'b00_0000_0100,
    ST_EMIT  = 10'b00_0000_1000,
    ST_XOR   = 10'b00_0001_0000,
    ST_M0    = 10'b00_0010_0000,
    ST_M1    = 10'b00_0100_0000,
    ST_M2    = 10'b00_1000_0000,
    ST_M3    = 10'b01_0000_0000,
    ST_FIN   = 10'b10_0000_0000
  } slg_state_e;

endpackage

@@ sv/slg_mul.sv @@
`timescale 1ns / 1ps

// shared 32x32 multiplier with registered product
module slg_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;
  logic [63:0] prod_d;

  assign prod_d = {32'b0, a_i} * {32'b0, b_i};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ sv/session_lifetime_guard.sv @@
`timescale 1ns / 1ps

// Session lifetime guard. Each validate beat on the input stream carries a
// session identifier and the current free-running tick; the wrapping tick gap
// since the last validation is added to a 64-bit elapsed count, and the
// session collapses for good when one gap exceeds the silent limit or the
// elapsed count exceeds lifespan_ms * MS_TICKS. A live session echoes its
// identifier (tuser low); a collapsed one returns a two-round 64-bit mix of
// identifier plus tick, rotated left by 13 (tuser high). A force beat
// (tuser high on the input) collapses the session and returns nothing.
// Steps: a force beat is handled as it is accepted. A live validate runs
// from acceptance to the result register through accept, gap/limit,
// compare and emit. A validate that ends collapsed runs through accept,
// gap/limit, compare, two mix rounds and final; when already collapsed the
// gap/limit and compare steps are skipped. Everything runs through one
// 32x32 multiplier; each mix round is an xor/shift step, then multiply
// steps that build the 64-bit product from three partial products. The
// emit and final steps hold while the result register is full and not
// drained. The input is not ready while an item is in work; the result sits
// in an output register, so the next item is taken while a result waits.
// Writing start_tick restarts the elapsed count and the gap reference; it
// does not revive a collapsed session. Configuration writes belong to idle
// periods.
module session_lifetime_guard #(
  parameter int unsigned MS_TICKS = slg_pkg::MS_TICKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [95:0]                   s_axis_tdata_i,  // ident[63:0], tick[95:64]
  input  logic                          s_axis_tuser_i,  // operation
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [63:0]                   m_axis_tdata_o,  // result_value[63:0]
  output logic                          m_axis_tuser_o,  // collapsed
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [slg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i
);

  slg_pkg::slg_state_e state_q, state_d;

  // configuration
  logic [31:0] lifespan_q;
  logic [31:0] silent_max_q;
  logic [31:0] lifespan_clamped;

  // session state
  logic [31:0] prev_tick_q;
  logic [63:0] elapsed_q;
  logic        dead_q;
  logic        silent_hit_q;

  // item in work
  logic [63:0] id_q;
  logic [31:0] now_q;
  logic [63:0] z_q;
  logic [63:0] acc_q;
  logic        round_q;

  // output register
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        out_coll_q;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic        in_acc;
  logic        out_free;
  logic [31:0] delta;
  logic        dead_now;
  logic [63:0] mix_const;
  logic [63:0] z_xor;
  logic [63:0] z_fin;
  logic [63:0] hash_val;
  logic [63:0] z_start;

  assign s_axis_tready_o = (state_q == slg_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign delta     = now_q - prev_tick_q;
  assign dead_now  = silent_hit_q || (elapsed_q > prod);
  assign mix_const = round_q ? slg_pkg::MIX_MUL_B : slg_pkg::MIX_MUL_A;
  assign z_xor     = round_q ? (z_q ^ (z_q >> slg_pkg::MIX_SHIFT_B))
                             : (z_q ^ (z_q >> slg_pkg::MIX_SHIFT_A));
  assign z_fin     = z_q ^ (z_q >> slg_pkg::MIX_SHIFT_C);
  assign hash_val  = (z_fin << slg_pkg::FINAL_ROTATE)
                   | (z_fin >> (64 - slg_pkg::FINAL_ROTATE));
  assign z_start   = s_axis_tdata_i[63:0] + {32'b0, s_axis_tdata_i[95:64]};

  // saturate lifespan writes into one second .. thirty days
  always_comb begin
    lifespan_clamped = cfg_wdata_i;
    if (cfg_wdata_i < slg_pkg::LIFESPAN_MIN_MS) begin
      lifespan_clamped = slg_pkg::LIFESPAN_MIN_MS;
    end else if (cfg_wdata_i > slg_pkg::LIFESPAN_MAX_MS) begin
      lifespan_clamped = slg_pkg::LIFESPAN_MAX_MS;
    end
  end

  // operand select: limit product, then the three low-half partial products
  always_comb begin
    mul_a = z_q[31:0];
    mul_b = mix_const[31:0];
    unique case (state_q)
      slg_pkg::ST_TRACK: begin
        mul_a = lifespan_q;
        mul_b = 32'(MS_TICKS);
      end
      slg_pkg::ST_M1: begin
        mul_a = z_q[31:0];
        mul_b = mix_const[63:32];
      end
      slg_pkg::ST_M2: begin
        mul_a = z_q[63:32];
        mul_b = mix_const[31:0];
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mix_const[31:0];
      end
    endcase
  end

  slg_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slg_pkg::ST_IDLE: begin
        if (in_acc && (s_axis_tuser_i == slg_pkg::OP_VALIDATE)) begin
          state_d = dead_q ? slg_pkg::ST_XOR : slg_pkg::ST_TRACK;
        end
      end
      slg_pkg::ST_TRACK: state_d = slg_pkg::ST_CHECK;
      slg_pkg::ST_CHECK: state_d = dead_now ? slg_pkg::ST_XOR : slg_pkg::ST_EMIT;
      slg_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = slg_pkg::ST_IDLE;
        end
      end
      slg_pkg::ST_XOR: state_d = slg_pkg::ST_M0;
      slg_pkg::ST_M0:  state_d = slg_pkg::ST_M1;
      slg_pkg::ST_M1:  state_d = slg_pkg::ST_M2;
      slg_pkg::ST_M2:  state_d = slg_pkg::ST_M3;
      slg_pkg::ST_M3:  state_d = round_q ? slg_pkg::ST_FIN : slg_pkg::ST_XOR;
      slg_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = slg_pkg::ST_IDLE;
        end
      end
      default: state_d = slg_pkg::ST_IDLE;
    endcase
  end

  // control and session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= slg_pkg::ST_IDLE;
      lifespan_q   <= slg_pkg::LIFESPAN_MIN_MS;
      silent_max_q <= slg_pkg::SILENT_RESET;
      prev_tick_q  <= slg_pkg::START_RESET;
      elapsed_q    <= 64'd0;
      dead_q       <= 1'b0;
      round_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          slg_pkg::CFG_LIFESPAN: lifespan_q <= lifespan_clamped;
          slg_pkg::CFG_SILENT:   silent_max_q <= cfg_wdata_i;
          slg_pkg::CFG_START: begin
            prev_tick_q <= cfg_wdata_i;
            elapsed_q   <= 64'd0;
          end
          default: ;
        endcase
      end

      if (in_acc && (s_axis_tuser_i == slg_pkg::OP_FORCE)) begin
        dead_q <= 1'b1;
      end

      if (state_q == slg_pkg::ST_IDLE) begin
        round_q <= 1'b0;
      end

      if (state_q == slg_pkg::ST_TRACK) begin
        prev_tick_q <= now_q;
        elapsed_q   <= elapsed_q + {32'b0, delta};
      end

      if ((state_q == slg_pkg::ST_CHECK) && dead_now) begin
        dead_q <= 1'b1;
      end

      if (state_q == slg_pkg::ST_M3) begin
        round_q <= 1'b1;
      end

      // result register: load has priority over drain
      if (((state_q == slg_pkg::ST_EMIT) || (state_q == slg_pkg::ST_FIN)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q  <= s_axis_tdata_i[63:0];
      now_q <= s_axis_tdata_i[95:64];
      z_q   <= z_start;
    end
    if (state_q == slg_pkg::ST_TRACK) begin
      silent_hit_q <= delta > silent_max_q;
    end
    if (state_q == slg_pkg::ST_XOR) begin
      z_q <= z_xor;
    end
    if (state_q == slg_pkg::ST_M1) begin
      acc_q <= prod;
    end
    if (state_q == slg_pkg::ST_M2) begin
      acc_q[63:32] <= acc_q[63:32] + prod[31:0];
    end
    if (state_q == slg_pkg::ST_M3) begin
      z_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
    end
    if ((state_q == slg_pkg::ST_EMIT) && out_free) begin
      out_data_q <= id_q;
      out_coll_q <= 1'b0;
    end
    if ((state_q == slg_pkg::ST_FIN) && out_free) begin
      out_data_q <= hash_val;
      out_coll_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_coll_q;

endmodule
